// ----- src/lps_pkg.sv -----
`timescale 1ns / 1ps

package lps_pkg;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  // Pattern codes, shared by the select field and the active pattern
  localparam logic [2:0] PAT_OFF       = 3'd0;
  localparam logic [2:0] PAT_PAIRING   = 3'd1;
  localparam logic [2:0] PAT_JOINING   = 3'd2;
  localparam logic [2:0] PAT_CONNECTED = 3'd3;
  localparam logic [2:0] PAT_ERROR     = 3'd4;
  localparam logic [2:0] PAT_FACTORY   = 3'd5;
  localparam logic [2:0] PAT_STARTUP   = 3'd6;
  localparam logic [2:0] PAT_STOP      = 3'd7;

  // Colour codes
  localparam logic [2:0] COL_OFF     = 3'd0;
  localparam logic [2:0] COL_RED     = 3'd1;
  localparam logic [2:0] COL_GREEN   = 3'd2;
  localparam logic [2:0] COL_BLUE    = 3'd3;
  localparam logic [2:0] COL_YELLOW  = 3'd4;
  localparam logic [2:0] COL_CYAN    = 3'd5;
  localparam logic [2:0] COL_MAGENTA = 3'd6;
  localparam logic [2:0] COL_WHITE   = 3'd7;

  localparam logic [7:0]  CONNECTED_LAST  = 8'd30;
  localparam logic [7:0]  STARTUP_LAST    = 8'd5;
  localparam logic [15:0] FIXED_PERIOD_MS = 16'd100;
  localparam logic [7:0]  ERROR_CYCLE     = 8'd10;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FAST_BLINK   = 3'd0,
    CFG_SLOW_BLINK   = 3'd1,
    CFG_DOUBLE_BLINK = 3'd2,
    CFG_RAPID_FLASH  = 3'd3,
    CFG_ERR_REPEATS  = 3'd4,
    CFG_RAINBOW      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] fast_blink_ms;
    logic [15:0] slow_blink_ms;
    logic [15:0] double_blink_ms;
    logic [15:0] rapid_flash_ms;
    logic [7:0]  error_repeats;
    logic [7:0]  rainbow_steps;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] pattern_select;
  } req_t;

  typedef struct packed {
    logic [2:0] colour_index;
    logic [2:0] active_pattern;
    logic       timer_running;
    logic       strip_refreshed;
  } res_t;

  // Remainder of an 8-bit value by six: quotient by reciprocal (171/1024),
  // exact for every value below 256.
  function automatic logic [2:0] mod6(input logic [7:0] v);
    logic [17:0] prod;
    logic [5:0]  quot;
    logic [8:0]  back;
    logic [8:0]  rem;
    prod = 18'(v) * 18'd171;
    quot = prod[15:10];
    back = 9'(quot) * 9'd6;
    rem  = 9'(v) - back;
    return rem[2:0];
  endfunction

  // Rainbow colour for a remainder by six
  function automatic logic [2:0] rainbow_colour(input logic [2:0] idx);
    logic [2:0] col;
    case (idx)
      3'd0:    col = COL_RED;
      3'd1:    col = COL_GREEN;
      3'd2:    col = COL_BLUE;
      3'd3:    col = COL_YELLOW;
      3'd4:    col = COL_CYAN;
      3'd5:    col = COL_MAGENTA;
      default: col = COL_OFF;
    endcase
    return col;
  endfunction

endpackage

// ----- src/lps_if.sv -----
`timescale 1ns / 1ps

interface lps_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] pattern_select;

  modport source (output valid, output req_type, output pattern_select, input ready);
  modport sink (input valid, input req_type, input pattern_select, output ready);
endinterface

interface lps_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] colour_index;
  logic [2:0] active_pattern;
  logic       timer_running;
  logic       strip_refreshed;

  modport source (output valid, output colour_index, output active_pattern,
                  output timer_running, output strip_refreshed, input ready);
  modport sink (input valid, input colour_index, input active_pattern,
                input timer_running, input strip_refreshed, output ready);
endinterface

// ----- src/lps_engine.sv -----
`timescale 1ns / 1ps

module lps_engine
  import lps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic [2:0]  pattern_q, pattern_d;
  logic [7:0]  phase_q, phase_d;
  logic [7:0]  step_q, step_d;
  logic        running_q, running_d;
  logic [15:0] presc_q, presc_d;
  logic [2:0]  colour_q, colour_d;
  logic        refreshed;

  logic [15:0] period_raw;
  logic [15:0] period;
  logic [16:0] presc_cnt;
  logic [7:0]  phase_inc;
  logic [7:0]  step_inc;

  always_comb begin
    case (pattern_q)
      PAT_PAIRING: period_raw = cfg_i.fast_blink_ms;
      PAT_JOINING: period_raw = cfg_i.slow_blink_ms;
      PAT_ERROR:   period_raw = cfg_i.double_blink_ms;
      PAT_FACTORY: period_raw = cfg_i.rapid_flash_ms;
      default:     period_raw = FIXED_PERIOD_MS;
    endcase
    // A period of zero steps on every tick.
    period = (period_raw == '0) ? 16'd1 : period_raw;
  end

  assign presc_cnt = {1'b0, presc_q} + 17'd1;
  assign phase_inc = phase_q + 8'd1;
  assign step_inc  = step_q + 8'd1;

  always_comb begin
    pattern_d = pattern_q;
    phase_d   = phase_q;
    step_d    = step_q;
    running_d = running_q;
    presc_d   = presc_q;
    colour_d  = colour_q;
    refreshed = 1'b0;
    if (fire_i) begin
      if (req_i.req_type == REQ_CMD) begin
        phase_d = '0;
        step_d  = '0;
        presc_d = '0;
        if (req_i.pattern_select == PAT_OFF || req_i.pattern_select == PAT_STOP) begin
          running_d = 1'b0;
          pattern_d = PAT_OFF;
          colour_d  = COL_OFF;
          refreshed = 1'b1;
        end else begin
          pattern_d = req_i.pattern_select;
          running_d = 1'b1;
        end
      end else if (running_q) begin
        if (presc_cnt >= {1'b0, period}) begin
          presc_d = '0;
          case (pattern_q) inside
            PAT_PAIRING, PAT_JOINING: begin
              if (phase_q[0]) begin
                colour_d = COL_OFF;
              end else begin
                colour_d = (pattern_q == PAT_PAIRING) ? COL_BLUE : COL_YELLOW;
              end
              phase_d   = phase_inc;
              refreshed = 1'b1;
            end
            PAT_CONNECTED, PAT_STARTUP: begin
              if (step_q == '0) begin
                colour_d  = (pattern_q == PAT_CONNECTED) ? COL_GREEN : COL_WHITE;
                step_d    = 8'd1;
                refreshed = 1'b1;
              end else begin
                step_d = step_inc;
                if (step_q >= ((pattern_q == PAT_CONNECTED) ? CONNECTED_LAST
                                                            : STARTUP_LAST)) begin
                  running_d = 1'b0;
                  pattern_d = PAT_OFF;
                  colour_d  = COL_OFF;
                  refreshed = 1'b1;
                end
              end
            end
            PAT_ERROR: begin
              colour_d = (phase_q < 8'd2 || (phase_q >= 8'd4 && phase_q < 8'd6))
                         ? COL_RED : COL_OFF;
              phase_d   = phase_inc;
              refreshed = 1'b1;
              if (phase_inc >= ERROR_CYCLE) begin
                phase_d = '0;
                step_d  = step_inc;
                // The colour is left as the last cycle step set it.
                if (step_inc >= cfg_i.error_repeats) begin
                  running_d = 1'b0;
                  pattern_d = PAT_OFF;
                end
              end
            end
            PAT_FACTORY: begin
              colour_d  = rainbow_colour(mod6(phase_q));
              phase_d   = phase_inc;
              step_d    = step_inc;
              refreshed = 1'b1;
              if (step_q >= cfg_i.rainbow_steps) begin
                running_d = 1'b0;
                pattern_d = PAT_OFF;
                colour_d  = COL_OFF;
              end
            end
            default: begin
              running_d = 1'b0;
              pattern_d = PAT_OFF;
              colour_d  = COL_OFF;
              refreshed = 1'b1;
            end
          endcase
        end else begin
          presc_d = presc_cnt[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PAT_OFF;
      phase_q   <= '0;
      step_q    <= '0;
      running_q <= 1'b0;
      presc_q   <= '0;
      colour_q  <= COL_OFF;
    end else begin
      pattern_q <= pattern_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
      running_q <= running_d;
      presc_q   <= presc_d;
      colour_q  <= colour_d;
    end
  end

  assign res_o.colour_index    = colour_d;
  assign res_o.active_pattern  = pattern_d;
  assign res_o.timer_running   = running_d;
  assign res_o.strip_refreshed = refreshed;

  // The timer runs exactly while some pattern is active.
  a_run_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q == (pattern_q != PAT_OFF))
    else $error("timer state and active pattern disagree");

  // A tick that arrives while stopped leaves everything alone.
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && req_i.req_type == REQ_TICK && !running_q) |=>
      ($stable(colour_q) && $stable(pattern_q) && !running_q))
    else $error("tick changed state while timer stopped");

  // The prescaler stays below the step period while running.
  a_presc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && req_i.req_type == REQ_TICK && running_q) |=> (presc_q < period))
    else $error("prescaler reached step period");

  // Error blink phase stays inside its ten-step cycle.
  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pattern_q == PAT_ERROR) |-> (phase_q < ERROR_CYCLE))
    else $error("error phase out of cycle");

endmodule

// ----- src/led_pattern_sequencer.sv -----
`timescale 1ns / 1ps

// LED pattern sequencer. Each request on req_i is either a one-millisecond
// tick or a command selecting a pattern (off, pairing blink, joining blink,
// connected, error double blink, factory reset rainbow, startup); every
// request produces exactly one result on res_o giving the colour now shown
// on all LEDs, the active pattern, whether the step timer runs and whether
// this request rewrote the colour. A request is taken into an input
// register and processed by combinational logic into a result register as
// soon as that register is free, so one request per clock is sustained
// while res_o.ready stays high. A result waits there until res_o.ready
// takes it, and the input side keeps accepting while a result waits, until
// both registers are full. Step periods and the error and rainbow limits
// are written through the cfg_* port (index 0 to 5) with no read-back;
// the user must write them only while idle; the block does not check it.

module led_pattern_sequencer
  import lps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lps_req_if.sink     req_i,
  lps_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;

  // Configuration registers, written by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_blink_ms   <= 16'd100;
      cfg_q.slow_blink_ms   <= 16'd500;
      cfg_q.double_blink_ms <= 16'd100;
      cfg_q.rapid_flash_ms  <= 16'd50;
      cfg_q.error_repeats   <= 8'd3;
      cfg_q.rainbow_steps   <= 8'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FAST_BLINK:   cfg_q.fast_blink_ms   <= cfg_data_i;
        CFG_SLOW_BLINK:   cfg_q.slow_blink_ms   <= cfg_data_i;
        CFG_DOUBLE_BLINK: cfg_q.double_blink_ms <= cfg_data_i;
        CFG_RAPID_FLASH:  cfg_q.rapid_flash_ms  <= cfg_data_i;
        CFG_ERR_REPEATS:  cfg_q.error_repeats   <= cfg_data_i[7:0];
        CFG_RAINBOW:      cfg_q.rainbow_steps   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register empties whenever the result register
  // can take a new result, so both sides move together at full rate.
  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  res_t out_q;
  res_t res_next;
  logic out_free;
  logic fire;
  logic in_take;

  assign out_free    = !out_valid_q || res_o.ready;
  assign fire        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || fire;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type       <= req_i.req_type;
      in_q.pattern_select <= req_i.pattern_select;
    end
    if (fire) begin
      out_q <= res_next;
    end
  end

  lps_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res_next)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.colour_index    = out_q.colour_index;
  assign res_o.active_pattern  = out_q.active_pattern;
  assign res_o.timer_running   = out_q.timer_running;
  assign res_o.strip_refreshed = out_q.strip_refreshed;

  // A request held in the input register stays there while the result
  // register is blocked.
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("request lost while result stalled");

  // A request processed always yields a result in the next cycle.
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed request produced no result");

  // Nothing is processed without a request waiting.
  a_fire_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> in_valid_q)
    else $error("processing without a request");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the LED pattern sequencer.
//
// The bench keeps its own copy of the sequencer state and configuration. Every
// request that the block accepts is run through that copy, and its result,
// or the plan's own where one is given, is queued. Every result that leaves
// the block is compared, field by field, against the oldest queued entry.
//
// The run has several parts:
//  - a short directed plan of requests;
//  - random phases, each under its own configuration, the last drawn at random;
//  - a rainbow run that takes the phase through every value.
//
// The configuration is only rewritten once the block has drained.
module testbench;
  import lps_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned LONG_HOLD     = 40;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SEQ_CAP       = 80;
  localparam int unsigned FIXED_CAP     = 110;
  localparam int unsigned PHASE_BUDGET  = 25;
  localparam int unsigned RAINBOW_LEN   = 6;

  // One row of the directed plan. The expected result is only filled in where
  // it is obvious by inspection; otherwise the predictor supplies it.
  typedef struct packed {
    req_t item;
    logic typed;
    res_t want;
  } plan_row_t;

  localparam req_t TICK_REQ = '{REQ_TICK, PAT_OFF};

  localparam int unsigned PLAN_LEN = 21;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{REQ_TICK, PAT_OFF},       1'b1, '{COL_OFF, PAT_OFF, 1'b0, 1'b0}},
    '{'{REQ_CMD,  PAT_OFF},       1'b1, '{COL_OFF, PAT_OFF, 1'b0, 1'b1}},
    '{'{REQ_CMD,  PAT_PAIRING},   1'b1, '{COL_OFF, PAT_PAIRING, 1'b1, 1'b0}},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_TICK, PAT_STOP},      1'b0, '0},
    '{'{REQ_CMD,  PAT_JOINING},   1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_CMD,  PAT_CONNECTED}, 1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_CMD,  PAT_ERROR},     1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_CMD,  PAT_FACTORY},   1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_CMD,  PAT_STARTUP},   1'b0, '0},
    '{'{REQ_TICK, PAT_OFF},       1'b0, '0},
    '{'{REQ_CMD,  PAT_STOP},      1'b1, '{COL_OFF, PAT_OFF, 1'b0, 1'b1}},
    '{'{REQ_TICK, PAT_OFF},       1'b1, '{COL_OFF, PAT_OFF, 1'b0, 1'b0}}
  };

  // Configurations for the random phases, fields in the order of cfg_t.
  // The first is a small setting, then all zero, a moderate one, then
  // everything at full scale.
  // The fifth runs long rainbows with a zero period and a one-tick blink.
  // The last is the reset setting.
  localparam int unsigned NUM_PHASES = 6;
  localparam cfg_t PHASES [NUM_PHASES] = '{
    '{16'd1, 16'd2, 16'd1, 16'd1, 8'd1, 8'd3},
    '{16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0},
    '{16'd3, 16'd4, 16'd2, 16'd2, 8'd2, 8'd5},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF},
    '{16'd1, 16'd1, 16'd1, 16'd0, 8'd3, 8'hFF},
    '{16'd100, 16'd500, 16'd100, 16'd50, 8'd3, 8'd30}
  };

  localparam logic [2:0] RAINBOW_SEQ [RAINBOW_LEN] = '{
    COL_RED, COL_GREEN, COL_BLUE, COL_YELLOW, COL_CYAN, COL_MAGENTA
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;

  lps_req_if req_if ();
  lps_res_if res_if ();

  led_pattern_sequencer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // The bench's own copy of the sequencer state and configuration.
  logic [2:0]  pat_now    = PAT_OFF;
  logic [7:0]  step_phase = '0;
  logic [7:0]  step_cnt   = '0;
  logic        timer_on   = 1'b0;
  logic [15:0] ms_count   = '0;
  logic [2:0]  lit_colour = COL_OFF;
  cfg_t        led_cfg    = '{16'd100, 16'd500, 16'd100, 16'd50, 8'd3, 8'd30};

  res_t        pending_leds[$];
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent      = 0;
  int unsigned useful_items    = 0;
  int unsigned cycle_count     = 0;

  // Both sides read burst: while it is set, neither side leaves gaps. The
  // sink picks up long_hold and then refuses results for a long stretch.
  logic burst     = 1'b0;
  logic long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one request and moves the bench's copy of the
  // state on. A start command clears the counters but leaves the colour alone.
  // A stop command blanks the strip. A tick only matters while the timer runs.
  function automatic res_t predict_led_result(req_t r);
    res_t        out;
    logic [15:0] period;
    logic [16:0] next_count;
    logic [7:0]  prev_cnt;
    logic        rewritten;
    rewritten = 1'b0;
    if (r.req_type == REQ_CMD) begin
      step_phase = '0;
      step_cnt   = '0;
      ms_count   = '0;
      if (r.pattern_select == PAT_OFF || r.pattern_select == PAT_STOP) begin
        timer_on   = 1'b0;
        pat_now    = PAT_OFF;
        lit_colour = COL_OFF;
        rewritten  = 1'b1;
      end else begin
        pat_now  = r.pattern_select;
        timer_on = 1'b1;
      end
    end else if (timer_on) begin
      // The period is looked up on every tick, so a new setting applies at
      // once. A period of zero behaves as a period of one.
      case (pat_now)
        PAT_PAIRING: period = led_cfg.fast_blink_ms;
        PAT_JOINING: period = led_cfg.slow_blink_ms;
        PAT_ERROR:   period = led_cfg.double_blink_ms;
        PAT_FACTORY: period = led_cfg.rapid_flash_ms;
        default:     period = FIXED_PERIOD_MS;
      endcase
      if (period == '0) begin
        period = 16'd1;
      end
      next_count = {1'b0, ms_count} + 17'd1;
      if (next_count >= {1'b0, period}) begin
        ms_count  = '0;
        rewritten = 1'b1;
        case (pat_now)
          PAT_PAIRING, PAT_JOINING: begin
            if (step_phase[0]) begin
              lit_colour = COL_OFF;
            end else begin
              lit_colour = (pat_now == PAT_PAIRING) ? COL_BLUE : COL_YELLOW;
            end
            step_phase = step_phase + 8'd1;
          end
          PAT_CONNECTED, PAT_STARTUP: begin
            // The colour is set on the first step and held. The pattern then
            // ends, blanking the strip, on the step after the last count.
            if (step_cnt == '0) begin
              lit_colour = (pat_now == PAT_CONNECTED) ? COL_GREEN : COL_WHITE;
              step_cnt   = 8'd1;
            end else begin
              prev_cnt = step_cnt;
              step_cnt = step_cnt + 8'd1;
              if (prev_cnt >= ((pat_now == PAT_CONNECTED) ? CONNECTED_LAST : STARTUP_LAST)) begin
                timer_on   = 1'b0;
                pat_now    = PAT_OFF;
                lit_colour = COL_OFF;
              end else begin
                rewritten = 1'b0;
              end
            end
          end
          PAT_ERROR: begin
            // Two short red flashes in a ten-step cycle. When the pattern
            // ends, the colour from the last step is kept.
            if (step_phase < 8'd2 || (step_phase >= 8'd4 && step_phase < 8'd6)) begin
              lit_colour = COL_RED;
            end else begin
              lit_colour = COL_OFF;
            end
            step_phase = step_phase + 8'd1;
            if (step_phase >= ERROR_CYCLE) begin
              step_phase = '0;
              step_cnt   = step_cnt + 8'd1;
              if (step_cnt >= led_cfg.error_repeats) begin
                timer_on = 1'b0;
                pat_now  = PAT_OFF;
              end
            end
          end
          PAT_FACTORY: begin
            lit_colour = RAINBOW_SEQ[step_phase % RAINBOW_LEN];
            step_phase = step_phase + 8'd1;
            prev_cnt   = step_cnt;
            step_cnt   = step_cnt + 8'd1;
            if (prev_cnt >= led_cfg.rainbow_steps) begin
              timer_on   = 1'b0;
              pat_now    = PAT_OFF;
              lit_colour = COL_OFF;
            end
          end
          default: begin
            timer_on   = 1'b0;
            pat_now    = PAT_OFF;
            lit_colour = COL_OFF;
          end
        endcase
      end else begin
        ms_count = next_count[15:0];
      end
    end
    out.colour_index    = lit_colour;
    out.active_pattern  = pat_now;
    out.timer_running   = timer_on;
    out.strip_refreshed = rewritten;
    return out;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at result %0d: %s is %0d, expected %0d",
             results_checked, what, got, want);
    mismatches++;
  endtask

  // Offers one request after a random gap and holds it until it is taken.
  // The gap is only opened by lowering valid, so valid is never lowered and
  // raised again in the same time step. The expected result is queued at
  // the edge that accepts the request.
  task automatic send_request(input req_t r, input logic typed, input res_t want);
    int unsigned gap;
    res_t        model_out;
    gap = burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid          = 1'b1;
    req_if.req_type       = r.req_type;
    req_if.pattern_select = r.pattern_select;
    do @(posedge clk); while (!req_if.ready);
    if (r.req_type == REQ_CMD || timer_on) begin
      useful_items++;
    end
    model_out = predict_led_result(r);
    pending_leds.push_back(typed ? want : model_out);
    items_sent++;
  endtask

  // Stops offering requests and waits until every outstanding result has
  // come back, then waits a little longer before returning.
  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
  endtask

  task automatic program_cfg(input cfg_t c);
    drain_results();
    write_reg(CFG_FAST_BLINK,   c.fast_blink_ms);
    write_reg(CFG_SLOW_BLINK,   c.slow_blink_ms);
    write_reg(CFG_DOUBLE_BLINK, c.double_blink_ms);
    write_reg(CFG_RAPID_FLASH,  c.rapid_flash_ms);
    write_reg(CFG_ERR_REPEATS,  16'(c.error_repeats));
    write_reg(CFG_RAINBOW,      16'(c.rainbow_steps));
    @(negedge clk);
    cfg_we  = 1'b0;
    led_cfg = c;
  endtask

  // Most sequences are well formed: a start command, then a run of ticks,
  // capped at SEQ_CAP or FIXED_CAP, and sometimes a stop. The rest is noise,
  // with random commands and ticks in any order. Ticks sent while the
  // sequencer is stopped do not count against the budget.
  task automatic run_sequences(input int unsigned budget);
    int unsigned start_count;
    int unsigned per;
    int unsigned need;
    int unsigned lim;
    int unsigned cap;
    int unsigned ticks;
    logic [2:0]  pat;
    req_t        r;
    start_count = useful_items;
    while (useful_items - start_count < budget) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 80) begin
        pat = 3'($urandom_range(PAT_PAIRING, PAT_STARTUP));
        send_request('{REQ_CMD, pat}, 1'b0, '0);
        cap = SEQ_CAP;
        case (pat)
          PAT_PAIRING: begin
            per  = led_cfg.fast_blink_ms;
            need = $urandom_range(1, 12);
          end
          PAT_JOINING: begin
            per  = led_cfg.slow_blink_ms;
            need = $urandom_range(1, 12);
          end
          PAT_ERROR: begin
            per  = led_cfg.double_blink_ms;
            need = ERROR_CYCLE * ((led_cfg.error_repeats == '0) ? 1 : led_cfg.error_repeats);
          end
          PAT_FACTORY: begin
            per  = led_cfg.rapid_flash_ms;
            need = led_cfg.rainbow_steps + 3;
          end
          default: begin
            // The fixed period is long, so reach at most the first step here.
            per  = FIXED_PERIOD_MS;
            need = $urandom_range(0, 1);
            cap  = FIXED_CAP;
          end
        endcase
        if (per == 0) begin
          per = 1;
        end
        lim = per * need + 2;
        if (lim > cap) begin
          lim = cap;
        end
        ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim) : lim;
        repeat (ticks) send_request(TICK_REQ, 1'b0, '0);
        if ($urandom_range(0, 2) == 0) begin
          send_request('{REQ_CMD, ($urandom_range(0, 1) != 0) ? PAT_STOP : PAT_OFF},
                       1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          r.req_type       = 1'($urandom_range(0, 1));
          r.pattern_select = 3'($urandom_range(0, 7));
          send_request(r, 1'b0, '0);
        end
      end
    end
    burst = 1'b0;
  endtask

  // Result sink. Before each result it holds ready low for a random number
  // of cycles, or for a long stretch when the stimulus asks for one. During
  // that stretch the block fills up and stops taking requests.
  initial begin : result_sink
    int unsigned wait_cycles;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      wait_cycles = burst ? 0 : $urandom_range(0, 5);
      if (long_hold) begin
        long_hold   = 1'b0;
        wait_cycles = LONG_HOLD;
      end
      if (wait_cycles != 0) begin
        res_if.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Result checker: every result taken is compared with the oldest entry in
  // the queue.
  always @(posedge clk) begin : check_result
    res_t seen;
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      seen = '{res_if.colour_index, res_if.active_pattern,
               res_if.timer_running, res_if.strip_refreshed};
      if (pending_leds.size() == 0) begin
        report_mismatch("unrequested result, colour_index", seen.colour_index, 0);
      end else begin
        want = pending_leds.pop_front();
        results_checked++;
        if (seen.colour_index != want.colour_index) begin
          report_mismatch("colour_index", seen.colour_index, want.colour_index);
        end
        if (seen.active_pattern != want.active_pattern) begin
          report_mismatch("active_pattern", seen.active_pattern, want.active_pattern);
        end
        if (seen.timer_running != want.timer_running) begin
          report_mismatch("timer_running", seen.timer_running, want.timer_running);
        end
        if (seen.strip_refreshed != want.strip_refreshed) begin
          report_mismatch("strip_refreshed", seen.strip_refreshed, want.strip_refreshed);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles, %0d results outstanding",
               cycle_count, pending_leds.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t rnd_cfg;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_FAST_BLINK;
    cfg_data              = '0;
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_TICK;
    req_if.pattern_select = PAT_OFF;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed plan, with one-tick periods so that the blink, error and
    // rainbow patterns all step, and a small rainbow limit so that the
    // rainbow ends within the plan.
    program_cfg('{16'd1, 16'd1, 16'd1, 16'd1, 8'd1, 8'd2});
    for (int i = 0; i < PLAN_LEN; i++) begin
      send_request(PLAN[i].item, PLAN[i].typed, PLAN[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_cfg(PHASES[p]);
      if (p == 2) begin
        long_hold = 1'b1;
      end
      run_sequences(PHASE_BUDGET);
      if (p == 4) begin
        // Rainbow right up to its largest limit with a zero period, so the
        // phase passes through every value before the pattern ends.
        send_request('{REQ_CMD, PAT_FACTORY}, 1'b0, '0);
        repeat (260) send_request(TICK_REQ, 1'b0, '0);
      end
    end

    rnd_cfg.fast_blink_ms   = 16'($urandom_range(1, 6));
    rnd_cfg.slow_blink_ms   = 16'($urandom_range(1, 6));
    rnd_cfg.double_blink_ms = 16'($urandom_range(1, 6));
    rnd_cfg.rapid_flash_ms  = 16'($urandom_range(1, 6));
    rnd_cfg.error_repeats   = 8'($urandom_range(1, 4));
    rnd_cfg.rainbow_steps   = 8'($urandom_range(0, 12));
    program_cfg(rnd_cfg);
    run_sequences(PHASE_BUDGET);
    send_request('{REQ_CMD, PAT_STOP}, 1'b0, '0);

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_leds.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_leds.size());
    end
    $display("Sent %0d requests (%0d of them acting on the sequencer), checked %0d results.",
             items_sent, useful_items, results_checked);
    $display("Covered every pattern and stop code, zero and full-scale settings, and a full rainbow.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
